FILE: design/rbc_pkg.sv
`default_nettype none

package rbc_pkg;

   // Verdict codes carried on the response channel.
   typedef enum logic [1:0] {
      VERDICT_FORWARD = 2'd0,
      VERDICT_BLOCK   = 2'd1,
      VERDICT_PONG    = 2'd2
   } verdict_type;

   // Blocklist table: number of entries and the longest entry in bytes.
   localparam int TABLE_PATTERNS = 9;
   localparam int PAT_MAX_BYTES  = 21;

   // Method prefixes: GET, POST, CONNECT and PING.
   localparam int PREFIX_COUNT     = 4;
   localparam int PREFIX_MAX_BYTES = 8;

   // Prefix candidate bits.
   localparam int PREFIX_GET     = 0;
   localparam int PREFIX_POST    = 1;
   localparam int PREFIX_CONNECT = 2;
   localparam int PREFIX_PING    = 3;

   // The string position counter stops at the longest prefix length.
   localparam logic [3:0] POS_LIMIT = 4'd8;

   typedef logic [PAT_MAX_BYTES*8-1:0]    pat_text_type;
   typedef logic [PREFIX_MAX_BYTES*8-1:0] prefix_text_type;

   // Blocklist entry text, right-justified: byte 0 holds the final character.
   function automatic pat_text_type pattern_text(input int idx);
      pat_text_type txt;
      begin
         txt = '0;
         case (idx)
            0: txt = pat_text_type'({"google", "syndication.com"});
            1: txt = pat_text_type'({"double", "click.net"});
            2: txt = pat_text_type'({"google", "-analytics.com"});
            3: txt = pat_text_type'({"face", "book.com/tr/"});
            4: txt = pat_text_type'({"ads.twit", "ter.com"});
            5: txt = pat_text_type'({"analytics.twit", "ter.com"});
            6: txt = pat_text_type'({"scorecard", "research.com"});
            7: txt = pat_text_type'("telemetry");
            8: txt = pat_text_type'({"crash", "lytics"});
            default: txt = '0;
         endcase
         return txt;
      end
   endfunction

   // Blocklist entry length in bytes.
   function automatic int pattern_len(input int idx);
      int len;
      begin
         len = 0;
         case (idx)
            0: len = 21;
            1: len = 15;
            2: len = 20;
            3: len = 16;
            4: len = 15;
            5: len = 21;
            6: len = 21;
            7: len = 9;
            8: len = 11;
            default: len = 0;
         endcase
         return len;
      end
   endfunction

   // Prefix text, right-justified: the first character sits highest.
   function automatic prefix_text_type prefix_text(input int idx);
      prefix_text_type txt;
      begin
         txt = '0;
         case (idx)
            PREFIX_GET:     txt = prefix_text_type'("GET ");
            PREFIX_POST:    txt = prefix_text_type'("POST ");
            PREFIX_CONNECT: txt = prefix_text_type'("CONNECT ");
            PREFIX_PING:    txt = prefix_text_type'("PING");
            default:        txt = '0;
         endcase
         return txt;
      end
   endfunction

   // Prefix length in bytes.
   function automatic logic [3:0] prefix_len(input int idx);
      logic [3:0] len;
      begin
         len = 4'd0;
         case (idx)
            PREFIX_GET:     len = 4'd4;
            PREFIX_POST:    len = 4'd5;
            PREFIX_CONNECT: len = 4'd8;
            PREFIX_PING:    len = 4'd4;
            default:        len = 4'd0;
         endcase
         return len;
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/request_blocklist_classifier_top.sv
// Request classifier: screens one request payload per frame.
// The request channel carries one payload byte per transaction in req_tdata,
// with req_tlast on the final byte of the payload. A zero byte ends the
// string; later bytes up to req_tlast are ignored. For each frame one
// response transaction carries the verdict: forward, block (method prefix
// plus a blocklist substring seen anywhere) or pong (payload begins with PING).
// Every byte is matched against all blocklist entries at once over a shift
// window, so a byte is taken in every cycle unless a pending verdict stalls;
// the verdict appears on rsp_tvalid in the cycle after the final byte is taken.
// The response sits in a single output register; while it waits, the next
// request is still taken if rsp_tready is high in the same cycle, so a
// stalled receiver holds back the request side only when a verdict is
// pending and not taken. Reset clears the window, the prefix tracking and
// any pending response; the window and prefix tracking are also cleared
// after every final byte. A frame without a final byte produces no response.
`default_nettype none

module request_blocklist_classifier_top #(
   parameter int WINDOW_BYTES  = 21,
   parameter int PATTERN_COUNT = 9
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_payload
   // Response channel.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [1:0] verdict, [7:2] zero
);

   localparam int ACTIVE_PATTERNS = (PATTERN_COUNT < rbc_pkg::TABLE_PATTERNS) ?
                                    PATTERN_COUNT : rbc_pkg::TABLE_PATTERNS;

   // State registers and their next values.
   logic [7:0]                          recent_bytes_ff [WINDOW_BYTES];
   logic [7:0]                          recent_bytes_in [WINDOW_BYTES];
   logic [3:0]                          byte_position_ff, byte_position_in;
   logic [rbc_pkg::PREFIX_COUNT-1:0]    prefix_cand_ff, prefix_cand_in;
   logic                                pattern_seen_ff, pattern_seen_in;
   logic                                string_ended_ff, string_ended_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rbc_pkg::verdict_type                verdict_ff, verdict_in;

   logic                                req_accept;
   logic                                take_byte;
   logic [7:0]                          shifted [WINDOW_BYTES];
   logic [ACTIVE_PATTERNS-1:0]          pat_hit;
   logic [rbc_pkg::PREFIX_COUNT-1:0]    prefix_miss;
   logic [rbc_pkg::PREFIX_COUNT-1:0]    prefix_hit;
   logic [3:0]                          position_upd;
   logic [rbc_pkg::PREFIX_COUNT-1:0]    cand_upd;
   logic                                seen_upd;
   logic                                ended_upd;
   rbc_pkg::verdict_type                verdict_calc;

   // A new transaction is taken unless a verdict waits and the receiver stalls.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign take_byte  = !string_ended_ff && (req_tdata != 8'd0);

   // Window as it stands once the current byte is shifted in.
   always_comb begin
      shifted[0] = req_tdata;
      for (int k = 1; k < WINDOW_BYTES; k++) begin
         shifted[k] = recent_bytes_ff[k-1];
      end
   end

   // One comparator bank per blocklist entry, all against the shifted window.
   for (genvar p = 0; p < ACTIVE_PATTERNS; p++) begin : g_pat
      localparam rbc_pkg::pat_text_type PAT_TEXT = rbc_pkg::pattern_text(p);
      localparam int PAT_LEN = rbc_pkg::pattern_len(p);

      always_comb begin
         pat_hit[p] = (PAT_LEN != 0) && (PAT_LEN <= WINDOW_BYTES);
         for (int k = 0; k < rbc_pkg::PAT_MAX_BYTES; k++) begin
            if (k < PAT_LEN && shifted[k] != PAT_TEXT[k*8 +: 8]) begin
               pat_hit[p] = 1'b0;
            end
         end
      end
   end

   // Prefix tracking: a candidate drops out on its first mismatching byte.
   for (genvar c = 0; c < rbc_pkg::PREFIX_COUNT; c++) begin : g_prefix
      localparam rbc_pkg::prefix_text_type PRE_TEXT = rbc_pkg::prefix_text(c);
      localparam logic [3:0] PRE_LEN = rbc_pkg::prefix_len(c);

      logic [2:0] char_idx;

      assign char_idx = 3'(PRE_LEN - 4'd1 - byte_position_ff);
      assign prefix_miss[c] = (byte_position_ff < PRE_LEN) &&
                              (req_tdata != PRE_TEXT[char_idx*8 +: 8]);
      assign prefix_hit[c] = cand_upd[c] && (position_upd >= PRE_LEN);
   end

   // State after this byte, before the end-of-frame clear.
   always_comb begin
      position_upd = byte_position_ff;
      cand_upd     = prefix_cand_ff;
      seen_upd     = pattern_seen_ff;
      ended_upd    = string_ended_ff;
      if (!string_ended_ff && req_tdata == 8'd0) begin
         ended_upd = 1'b1;
      end
      if (take_byte) begin
         cand_upd = prefix_cand_ff & ~prefix_miss;
         if (byte_position_ff < rbc_pkg::POS_LIMIT) begin
            position_upd = byte_position_ff + 4'd1;
         end
         if (|pat_hit) begin
            seen_upd = 1'b1;
         end
      end
   end

   // Verdict from the updated state.
   always_comb begin
      if (prefix_hit[rbc_pkg::PREFIX_GET] || prefix_hit[rbc_pkg::PREFIX_POST] ||
          prefix_hit[rbc_pkg::PREFIX_CONNECT]) begin
         verdict_calc = seen_upd ? rbc_pkg::VERDICT_BLOCK : rbc_pkg::VERDICT_FORWARD;
      end else if (prefix_hit[rbc_pkg::PREFIX_PING]) begin
         verdict_calc = rbc_pkg::VERDICT_PONG;
      end else begin
         verdict_calc = rbc_pkg::VERDICT_FORWARD;
      end
   end

   // Next state: commit on an accepted transaction, clear after a final byte.
   always_comb begin
      recent_bytes_in  = recent_bytes_ff;
      byte_position_in = byte_position_ff;
      prefix_cand_in   = prefix_cand_ff;
      pattern_seen_in  = pattern_seen_ff;
      string_ended_in  = string_ended_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      verdict_in       = verdict_ff;
      if (req_accept) begin
         if (req_tlast) begin
            for (int k = 0; k < WINDOW_BYTES; k++) begin
               recent_bytes_in[k] = 8'd0;
            end
            byte_position_in = 4'd0;
            prefix_cand_in   = '1;
            pattern_seen_in  = 1'b0;
            string_ended_in  = 1'b0;
            rsp_valid_in     = 1'b1;
            verdict_in       = verdict_calc;
         end else begin
            if (take_byte) begin
               recent_bytes_in = shifted;
            end
            byte_position_in = position_upd;
            prefix_cand_in   = cand_upd;
            pattern_seen_in  = seen_upd;
            string_ended_in  = ended_upd;
         end
      end
   end

   // Control and window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_BYTES; k++) begin
            recent_bytes_ff[k] <= 8'd0;
         end
         byte_position_ff <= 4'd0;
         prefix_cand_ff   <= '1;
         pattern_seen_ff  <= 1'b0;
         string_ended_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         recent_bytes_ff  <= recent_bytes_in;
         byte_position_ff <= byte_position_in;
         prefix_cand_ff   <= prefix_cand_in;
         pattern_seen_ff  <= pattern_seen_in;
         string_ended_ff  <= string_ended_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Verdict payload register.
   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff};

   // A final byte always produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> rsp_tvalid)
      else $error("final byte taken without a response");

   // All per-frame state is back to its initial value after a final byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (byte_position_ff == 4'd0 && prefix_cand_ff == '1 &&
                                     !pattern_seen_ff && !string_ended_ff))
      else $error("frame state not cleared after final byte");

   // The position counter never passes its saturation point.
   assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= rbc_pkg::POS_LIMIT)
      else $error("byte position past its limit");

   // Once the string has ended, further bytes leave the tracking unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_tlast && string_ended_ff) |=>
         ($stable(byte_position_ff) && $stable(prefix_cand_ff) && $stable(pattern_seen_ff)))
      else $error("bytes after string end changed the tracking state");

   // A pending response is never the unused verdict code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("undefined verdict code on the response channel");

endmodule

`default_nettype wire
